/* rtl/core/sopc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register codes and types for the smooth obstacle
// Poisson coefficient block. Depends on nothing else.
package sopc_pkg;

    // Grid defaults for the top-level parameters.
    localparam int GRID_WIDTH_DEF  = 1024;
    localparam int GRID_HEIGHT_DEF = 1024;

    // Field and port widths.
    localparam int COL_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W     = 56;
    localparam int PHI_W      = 17;
    localparam int M_W        = 13;

    // Q16.16 unity.
    localparam int ONE_Q16 = 65536;

    // Coefficient division: numerator is the permeability sum shifted by FRAC_SHIFT.
    localparam int PERM_W     = 22;
    localparam int FRAC_SHIFT = 31;
    localparam int CQ_W       = PERM_W + FRAC_SHIFT;
    localparam int CDIV_STG   = CQ_W;
    localparam int DSQ_W      = 64;
    localparam int CDIV_W     = 68;

    // Fraction lane depth: front end, square root, span select, divider, back end.
    localparam int SQRT_STG  = 36;
    localparam int SDIV_STG  = 16;
    localparam int FRAC_LAT  = 5 + SQRT_STG + 1 + SDIV_STG + 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_DX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_DY  = 3'd5;

    // Geometry handed to each fraction lane: dx and dy in units of 2^-16, the rest in units of 2^-17.
    typedef struct packed {
        logic [31:0] dx;
        logic [31:0] dy;
        logic [32:0] cx2;
        logic [32:0] cy2;
        logic [32:0] r2;
        logic [32:0] w2;
        logic [33:0] dw4;
    } t_frac_cfg;

endpackage

/* rtl/core/sopc_in_if.sv */
`timescale 1ns / 1ps
// Input channel carrying one grid cell index per transfer.
// Depends on sopc_pkg for the field widths.
interface sopc_in_if;
    logic                        valid;
    logic                        ready;
    logic [sopc_pkg::COL_W-1:0]  cell_col;
    logic [sopc_pkg::COL_W-1:0]  cell_row;

    modport source (output valid, cell_col, cell_row, input ready);
    modport sink   (input valid, cell_col, cell_row, output ready);
endinterface

/* rtl/core/sopc_out_if.sv */
`timescale 1ns / 1ps
// Output channel carrying one set of stencil coefficients per transfer.
// Depends on sopc_pkg for the field widths.
interface sopc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                solid_cell;
    logic [sopc_pkg::COEF_W-1:0]         diag_coef;
    logic signed [sopc_pkg::COEF_W-1:0]  offset_x_coef;
    logic signed [sopc_pkg::COEF_W-1:0]  offset_y_coef;

    modport source (output valid, solid_cell, diag_coef, offset_x_coef, offset_y_coef,
                    input ready);
    modport sink   (input valid, solid_cell, diag_coef, offset_x_coef, offset_y_coef,
                    output ready);
endinterface

/* rtl/core/sopc_frac.sv */
`timescale 1ns / 1ps
// One solid-fraction lane: distance, pipelined square root, smoothstep
// division and cubic. Depends on sopc_pkg.
module sopc_frac (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [sopc_pkg::M_W-1:0]    i_mx,
    input  logic signed [sopc_pkg::M_W-1:0]    i_my,
    input  sopc_pkg::t_frac_cfg                i_cfg,
    output logic [sopc_pkg::PHI_W-1:0]         o_phi
);
    import sopc_pkg::*;

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_ONE  = 2'd1;
    localparam logic [1:0] SEL_DIV  = 2'd2;
    localparam logic [51:0] HALF_LSB = 52'd2147483648;

    // Stage 1: signed distance components.
    logic signed [45:0] w_mx, w_my, w_dx, w_dy, w_cx, w_cy;
    logic signed [45:0] r1_ddx, r1_ddy;

    assign w_mx = {{(46-M_W){i_mx[M_W-1]}}, i_mx};
    assign w_my = {{(46-M_W){i_my[M_W-1]}}, i_my};
    assign w_dx = {14'd0, i_cfg.dx};
    assign w_dy = {14'd0, i_cfg.dy};
    assign w_cx = {13'd0, i_cfg.cx2};
    assign w_cy = {13'd0, i_cfg.cy2};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ddx <= w_mx * w_dx - w_cx;
            r1_ddy <= w_my * w_dy - w_cy;
        end
    end

    // Stage 2: magnitudes and the far-point flag.
    logic [45:0] w_absx, w_absy;
    logic [34:0] r2_ax, r2_ay;
    logic        r2_far;

    assign w_absx = r1_ddx[45] ? -r1_ddx : r1_ddx;
    assign w_absy = r1_ddy[45] ? -r1_ddy : r1_ddy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ax  <= w_absx[34:0];
            r2_ay  <= w_absy[34:0];
            r2_far <= (|w_absx[45:35]) | (|w_absy[45:35]);
        end
    end

    // Stage 3: partial products of the squares.
    logic [33:0] r3_xhh, r3_yhh;
    logic [34:0] r3_xhl, r3_yhl;
    logic [35:0] r3_xll, r3_yll;
    logic        r3_far;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_xhh <= r2_ax[34:18] * r2_ax[34:18];
            r3_xhl <= r2_ax[34:18] * r2_ax[17:0];
            r3_xll <= r2_ax[17:0] * r2_ax[17:0];
            r3_yhh <= r2_ay[34:18] * r2_ay[34:18];
            r3_yhl <= r2_ay[34:18] * r2_ay[17:0];
            r3_yll <= r2_ay[17:0] * r2_ay[17:0];
            r3_far <= r2_far;
        end
    end

    // Stage 4: assemble the two squares.
    logic [69:0] r4_sqx, r4_sqy;
    logic        r4_far;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sqx <= {r3_xhh, 36'd0} + {16'd0, r3_xhl, 19'd0} + {34'd0, r3_xll};
            r4_sqy <= {r3_yhh, 36'd0} + {16'd0, r3_yhl, 19'd0} + {34'd0, r3_yll};
            r4_far <= r3_far;
        end
    end

    // Stage 5 onwards: one root bit per stage, remainder form.
    logic [70:0]           r_rem  [0:SQRT_STG];
    logic [SQRT_STG-1:0]   r_root [0:SQRT_STG];
    logic                  r_sfar [0:SQRT_STG];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, r4_sqx} + {1'b0, r4_sqy};
            r_root[0] <= '0;
            r_sfar[0] <= r4_far;
        end
    end

    for (genvar k = 0; k < SQRT_STG; k++) begin : g_sqrt
        localparam int B = SQRT_STG - 1 - k;
        logic [71:0] w_try;
        logic        w_ge;

        assign w_try = ({36'd0, r_root[k]} << (B + 1)) + (72'd1 << (2 * B));
        assign w_ge  = {1'b0, r_rem[k]} >= w_try;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? 71'({1'b0, r_rem[k]} - w_try) : r_rem[k];
                r_root[k+1] <= w_ge ? (r_root[k] | (36'd1 << B)) : r_root[k];
                r_sfar[k+1] <= r_sfar[k];
            end
        end
    end

    // Position within the smooth edge: clamp low, clamp high or divide.
    logic signed [37:0] w_u, w_w2, w_num;
    logic [1:0]         w_sel;
    logic [33:0]        r_drem [0:SDIV_STG];
    logic [SDIV_STG-1:0] r_dq  [0:SDIV_STG];
    logic [1:0]         r_dsel [0:SDIV_STG];

    assign w_u   = $signed({5'd0, i_cfg.r2}) - $signed({2'd0, r_root[SQRT_STG]});
    assign w_w2  = $signed({5'd0, i_cfg.w2});
    assign w_num = w_u + w_w2;

    always_comb begin
        if (r_sfar[SQRT_STG] || (w_u <= -w_w2)) begin
            w_sel = SEL_ZERO;
        end else if (w_u >= w_w2) begin
            w_sel = SEL_ONE;
        end else begin
            w_sel = SEL_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drem[0] <= w_num[33:0];
            r_dq[0]   <= '0;
            r_dsel[0] <= w_sel;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar k = 0; k < SDIV_STG; k++) begin : g_sdiv
        logic [34:0] w_sh;
        logic        w_ge;

        assign w_sh = {r_drem[k], 1'b0};
        assign w_ge = w_sh >= {1'b0, i_cfg.dw4};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[k+1] <= w_ge ? 34'(w_sh - {1'b0, i_cfg.dw4}) : w_sh[33:0];
                r_dq[k+1]   <= {r_dq[k][SDIV_STG-2:0], w_ge};
                r_dsel[k+1] <= r_dsel[k];
            end
        end
    end

    // Smoothstep argument s in Q1.16.
    logic [16:0] w_s, r_s;

    always_comb begin
        case (r_dsel[SDIV_STG])
            SEL_ONE: w_s = 17'(ONE_Q16);
            SEL_DIV: w_s = {1'b0, r_dq[SDIV_STG]};
            default: w_s = '0;
        endcase
    end

    // Cubic s*s*(3-2s) over two multiplier stages, then rounding.
    logic [33:0] r_ss;
    logic [17:0] r_t3;
    logic [51:0] r_p, w_pr;
    logic [PHI_W-1:0] r_phi;

    assign w_pr = r_p + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s   <= w_s;
            r_ss  <= r_s * r_s;
            r_t3  <= 18'(3 * ONE_Q16) - {r_s, 1'b0};
            r_p   <= r_ss * r_t3;
            r_phi <= w_pr[48:32];
        end
    end

    assign o_phi = r_phi;

endmodule

/* rtl/core/smooth_obstacle_poisson_coefficients_top.sv */
`timescale 1ns / 1ps
// Top level of the smooth obstacle Poisson coefficient block.
// Depends on sopc_pkg, sopc_in_if, sopc_out_if and sopc_frac.
//
// Usage:
//   i_cell carries one cell index (cell_col, cell_row) per transfer; o_coef
//   returns exactly one coefficient set per cell, in order. Registers are
//   written through i_cfg_we / i_cfg_idx / i_cfg_data while no cell is in
//   flight; an index above cell_dy is ignored.
//   Throughput is one cell per clock while the skid stage is empty. A cell
//   passes through the fraction lanes (square root, then smoothstep
//   divider), the face permeability register, the bit-per-stage
//   coefficient divider, the final-selection register and the output
//   register on its way to o_coef.valid.
//   Five fraction lanes run side by side for the centre and its neighbours.
//   The output register is backed by a one-entry skid stage, so a cell is
//   still taken while a result waits; the whole pipeline holds only once the
//   skid stage fills, and nothing is lost or repeated while it holds.
//   Reset is synchronous and active low: it empties the pipeline and output
//   and returns the registers to a centre at the origin, zero radius, zero
//   transition width and unit spacing.
module smooth_obstacle_poisson_coefficients_top #(
    parameter int GRID_WIDTH  = sopc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = sopc_pkg::GRID_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sopc_in_if.sink                            i_cell,
    sopc_out_if.source                         o_coef,
    input  logic                               i_cfg_we,
    input  logic [sopc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sopc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sopc_pkg::*;

    // Configuration registers.
    logic [31:0] r_center_x, r_center_y, r_radius, r_trans_w, r_cell_dx, r_cell_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
            r_trans_w  <= '0;
            r_cell_dx  <= 32'(ONE_Q16);
            r_cell_dy  <= 32'(ONE_Q16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                CFG_TRANS_W:  r_trans_w  <= i_cfg_data;
                CFG_CELL_DX:  r_cell_dx  <= i_cfg_data;
                CFG_CELL_DY:  r_cell_dy  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective spacing and width; a zero spacing counts as one LSB.
    logic [31:0] w_dx_eff, w_dy_eff, w_w_eff;
    t_frac_cfg   w_fcfg;

    assign w_dx_eff = (r_cell_dx == '0) ? 32'd1 : r_cell_dx;
    assign w_dy_eff = (r_cell_dy == '0) ? 32'd1 : r_cell_dy;
    assign w_w_eff  = (r_trans_w == '0) ? w_dx_eff : r_trans_w;

    assign w_fcfg.dx  = w_dx_eff;
    assign w_fcfg.dy  = w_dy_eff;
    assign w_fcfg.cx2 = {r_center_x, 1'b0};
    assign w_fcfg.cy2 = {r_center_y, 1'b0};
    assign w_fcfg.r2  = {r_radius, 1'b0};
    assign w_fcfg.w2  = {w_w_eff, 1'b0};
    assign w_fcfg.dw4 = {w_w_eff, 2'b0};

    // Coefficient divisors 10*d*d; settle long before a cell reaches the divider.
    logic [DSQ_W-1:0]  r_dsq_x, r_dsq_y;
    logic [CDIV_W-1:0] r_cdiv_x, r_cdiv_y;

    always_ff @(posedge i_clk) begin
        r_dsq_x  <= w_dx_eff * w_dx_eff;
        r_dsq_y  <= w_dy_eff * w_dy_eff;
        r_cdiv_x <= {1'b0, r_dsq_x, 3'b0} + {3'b0, r_dsq_x, 1'b0};
        r_cdiv_y <= {1'b0, r_dsq_y, 3'b0} + {3'b0, r_dsq_y, 1'b0};
    end

    // Pipeline advances whenever the skid stage is empty.
    logic r_skid_v, r_out_v, w_en, w_in_grid;

    assign w_en         = !r_skid_v;
    assign i_cell.ready = w_en;

    assign w_in_grid = (i_cell.cell_col != '0) && (i_cell.cell_row != '0)
                    && (32'(i_cell.cell_col) <= 32'(GRID_WIDTH))
                    && (32'(i_cell.cell_row) <= 32'(GRID_HEIGHT));

    // Doubled sample positions 2i-1+2k for the centre and its neighbours.
    logic signed [M_W-1:0] w_bx, w_by, w_mxc, w_mxl, w_mxr, w_myc, w_myb, w_myt;

    assign w_bx  = {1'b0, i_cell.cell_col, 1'b0};
    assign w_by  = {1'b0, i_cell.cell_row, 1'b0};
    assign w_mxc = w_bx - 13'sd1;
    assign w_mxl = w_bx - 13'sd3;
    assign w_mxr = w_bx + 13'sd1;
    assign w_myc = w_by - 13'sd1;
    assign w_myb = w_by - 13'sd3;
    assign w_myt = w_by + 13'sd1;

    // Fraction lanes.
    logic [PHI_W-1:0] w_phi_c, w_phi_l, w_phi_r, w_phi_b, w_phi_t;

    sopc_frac u_frac_c (.i_clk(i_clk), .i_en(w_en), .i_mx(w_mxc), .i_my(w_myc),
                        .i_cfg(w_fcfg), .o_phi(w_phi_c));
    sopc_frac u_frac_l (.i_clk(i_clk), .i_en(w_en), .i_mx(w_mxl), .i_my(w_myc),
                        .i_cfg(w_fcfg), .o_phi(w_phi_l));
    sopc_frac u_frac_r (.i_clk(i_clk), .i_en(w_en), .i_mx(w_mxr), .i_my(w_myc),
                        .i_cfg(w_fcfg), .o_phi(w_phi_r));
    sopc_frac u_frac_b (.i_clk(i_clk), .i_en(w_en), .i_mx(w_mxc), .i_my(w_myb),
                        .i_cfg(w_fcfg), .o_phi(w_phi_b));
    sopc_frac u_frac_t (.i_clk(i_clk), .i_en(w_en), .i_mx(w_mxc), .i_my(w_myt),
                        .i_cfg(w_fcfg), .o_phi(w_phi_t));

    // Valid and in-grid flags travelling alongside the lanes.
    logic r_fv  [1:FRAC_LAT];
    logic r_fin [1:FRAC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= FRAC_LAT; k++) begin
                r_fv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_fv[1] <= i_cell.valid;
            for (int k = 2; k <= FRAC_LAT; k++) begin
                r_fv[k] <= r_fv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin[1] <= w_in_grid;
            for (int k = 2; k <= FRAC_LAT; k++) begin
                r_fin[k] <= r_fin[k-1];
            end
        end
    end

    // Solid test and face permeability sums, in units of 1/(10*2^17).
    logic                w_solid;
    logic [18:0]         w_hx, w_hy;
    logic [PERM_W-1:0]   w_nx, w_ny;

    assign w_solid = ({1'b0, w_phi_c, 3'b0} + {3'b0, w_phi_c, 1'b0}) > 21'(9 * ONE_Q16);
    assign w_hx = 19'(4 * ONE_Q16) - {1'b0, w_phi_c, 1'b0} - {2'b0, w_phi_l} - {2'b0, w_phi_r};
    assign w_hy = 19'(4 * ONE_Q16) - {1'b0, w_phi_c, 1'b0} - {2'b0, w_phi_b} - {2'b0, w_phi_t};
    assign w_nx = {w_hx, 3'b0} + {2'b0, w_hx, 1'b0} + 22'(4 * ONE_Q16);
    assign w_ny = {w_hy, 3'b0} + {2'b0, w_hy, 1'b0} + 22'(4 * ONE_Q16);

    // Coefficient divider pipeline, stage 0 holds the permeability sums.
    logic              r_cv   [0:CDIV_STG];
    logic              r_cin  [0:CDIV_STG];
    logic              r_csol [0:CDIV_STG];
    logic [PERM_W-1:0] r_nx   [0:CDIV_STG];
    logic [PERM_W-1:0] r_ny   [0:CDIV_STG];
    logic [CDIV_W-1:0] r_rx   [0:CDIV_STG];
    logic [CDIV_W-1:0] r_ry   [0:CDIV_STG];
    logic [CQ_W-1:0]   r_qx   [0:CDIV_STG];
    logic [CQ_W-1:0]   r_qy   [0:CDIV_STG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CDIV_STG; k++) begin
                r_cv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_cv[0] <= r_fv[FRAC_LAT];
            for (int k = 1; k <= CDIV_STG; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cin[0]  <= r_fin[FRAC_LAT];
            r_csol[0] <= w_solid;
            r_nx[0]   <= w_nx;
            r_ny[0]   <= w_ny;
            r_rx[0]   <= '0;
            r_ry[0]   <= '0;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    // One quotient bit of floor(n * 2^31 / (10*d*d)) per stage.
    for (genvar k = 0; k < CDIV_STG; k++) begin : g_cdiv
        localparam int BI = CQ_W - 1 - k;
        logic            w_nbx, w_nby, w_gex, w_gey;
        logic [CDIV_W:0] w_shx, w_shy;

        if (BI >= FRAC_SHIFT) begin : g_num
            assign w_nbx = r_nx[k][BI-FRAC_SHIFT];
            assign w_nby = r_ny[k][BI-FRAC_SHIFT];
        end else begin : g_zero
            assign w_nbx = 1'b0;
            assign w_nby = 1'b0;
        end

        assign w_shx = {r_rx[k], w_nbx};
        assign w_shy = {r_ry[k], w_nby};
        assign w_gex = w_shx >= {1'b0, r_cdiv_x};
        assign w_gey = w_shy >= {1'b0, r_cdiv_y};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cin[k+1]  <= r_cin[k];
                r_csol[k+1] <= r_csol[k];
                r_nx[k+1]   <= r_nx[k];
                r_ny[k+1]   <= r_ny[k];
                r_rx[k+1]   <= w_gex ? CDIV_W'(w_shx - {1'b0, r_cdiv_x}) : w_shx[CDIV_W-1:0];
                r_ry[k+1]   <= w_gey ? CDIV_W'(w_shy - {1'b0, r_cdiv_y}) : w_shy[CDIV_W-1:0];
                r_qx[k+1]   <= {r_qx[k][CQ_W-2:0], w_gex};
                r_qy[k+1]   <= {r_qy[k][CQ_W-2:0], w_gey};
            end
        end
    end

    // Final selection: outside grid, solid cell or normal stencil.
    logic              r_lv, r_lsol;
    logic [COEF_W-1:0] r_ldiag, r_loffx, r_loffy;
    logic              w_fsol;
    logic [COEF_W-1:0] w_fdiag, w_foffx, w_foffy, w_tdiag, w_toffx, w_toffy;

    assign w_tdiag = COEF_W'(r_qx[CDIV_STG]) + COEF_W'(r_qy[CDIV_STG]);
    assign w_toffx = COEF_W'(0) - COEF_W'(r_qx[CDIV_STG] >> 1);
    assign w_toffy = COEF_W'(0) - COEF_W'(r_qy[CDIV_STG] >> 1);

    always_comb begin
        if (!r_cin[CDIV_STG]) begin
            w_fsol  = 1'b0;
            w_fdiag = '0;
            w_foffx = '0;
            w_foffy = '0;
        end else if (r_csol[CDIV_STG]) begin
            w_fsol  = 1'b1;
            w_fdiag = '1;
            w_foffx = '0;
            w_foffy = '0;
        end else begin
            w_fsol  = 1'b0;
            w_fdiag = w_tdiag;
            w_foffx = w_toffx;
            w_foffy = w_toffy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else if (w_en) begin
            r_lv <= r_cv[CDIV_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lsol  <= w_fsol;
            r_ldiag <= w_fdiag;
            r_loffx <= w_foffx;
            r_loffy <= w_foffy;
        end
    end

    // Output register with a skid stage behind it.
    logic              r_sk_sol, r_out_sol;
    logic [COEF_W-1:0] r_sk_diag, r_sk_offx, r_sk_offy;
    logic [COEF_W-1:0] r_out_diag, r_out_offx, r_out_offy;
    logic              w_out_free;

    assign w_out_free = !r_out_v || o_coef.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_lv;
            end
        end else if (r_lv && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_v) begin
                r_out_sol  <= r_sk_sol;
                r_out_diag <= r_sk_diag;
                r_out_offx <= r_sk_offx;
                r_out_offy <= r_sk_offy;
            end else begin
                r_out_sol  <= r_lsol;
                r_out_diag <= r_ldiag;
                r_out_offx <= r_loffx;
                r_out_offy <= r_loffy;
            end
        end else if (w_en) begin
            r_sk_sol  <= r_lsol;
            r_sk_diag <= r_ldiag;
            r_sk_offx <= r_loffx;
            r_sk_offy <= r_loffy;
        end
    end

    assign o_coef.valid         = r_out_v;
    assign o_coef.solid_cell    = r_out_sol;
    assign o_coef.diag_coef     = r_out_diag;
    assign o_coef.offset_x_coef = r_out_offx;
    assign o_coef.offset_y_coef = r_out_offy;

endmodule

/* rtl/core/sopc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the coefficient output of the top level, and the
// bind that attaches them. Depends on sopc_pkg and the top level.
module sopc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic                               i_solid,
    input  logic [sopc_pkg::COEF_W-1:0]        i_diag,
    input  logic [sopc_pkg::COEF_W-1:0]        i_offx,
    input  logic [sopc_pkg::COEF_W-1:0]        i_offy
);
    import sopc_pkg::*;

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transfer withdrawn while stalled");

    // A stalled result does not change.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_solid) && $stable(i_diag) && $stable(i_offx) && $stable(i_offy))
        else $error("output payload changed while stalled");

    // A solid cell has a saturated diagonal and no neighbour coupling.
    a_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_solid |-> (i_diag == '1) && (i_offx == '0) && (i_offy == '0))
        else $error("solid cell with wrong coefficients");

    // Neighbour coefficients of a fluid cell are never positive.
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_solid |->
            (i_offx[COEF_W-1] || (i_offx == '0)) && (i_offy[COEF_W-1] || (i_offy == '0)))
        else $error("positive neighbour coefficient");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind smooth_obstacle_poisson_coefficients_top sopc_checker u_sopc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_coef.valid),
    .i_out_ready (o_coef.ready),
    .i_solid     (o_coef.solid_cell),
    .i_diag      (o_coef.diag_coef),
    .i_offx      (o_coef.offset_x_coef),
    .i_offy      (o_coef.offset_y_coef)
);
